// ----- rtl/core/jsu_pkg.sv -----
// Shared types, codes and helpers for the JSON string unescape block.
// Depends on nothing; imported by every module of the block.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_DATA         = 3'd0,
    ST_CLOSED       = 3'd1,
    ST_BAD_HEX      = 3'd2,
    ST_UNSUPPORTED  = 3'd3,
    ST_UNTERMINATED = 3'd4,
    ST_INCOMPLETE   = 3'd5
  } status_e;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlReturn    = 8'h0D;
  localparam logic [7:0] CtlTab       = 8'h09;

  localparam logic [15:0] OneByteMax = 16'h007F;
  localparam logic [15:0] TwoByteMax = 16'h07FF;
  localparam logic [7:0]  LeadTwo    = 8'hC0;
  localparam logic [7:0]  LeadThree  = 8'hE0;
  localparam logic [7:0]  ContMark   = 8'h80;

  // Group of results that one input word produces.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    status_e                    status;  // applies to the first result only
    logic [1:0]                 count;   // 0 to 3 results
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t    n;
    logic [7:0] diff;
    n    = '0;
    diff = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        diff = c - 8'h30;
        n.ok = 1'b1;
      end
      [8'h61:8'h66]: begin
        diff = c - 8'h57;
        n.ok = 1'b1;
      end
      [8'h41:8'h46]: begin
        diff = c - 8'h37;
        n.ok = 1'b1;
      end
      default: n.ok = 1'b0;
    endcase
    n.val = diff[3:0];
    return n;
  endfunction

endpackage

// ----- rtl/core/jsu_decode.sv -----
// Escape decoder: mode, hex gathering and UTF-8 encoding for one word.
// Depends on jsu_pkg; state advances only when the word moves on.
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       data_byte_i,
  input  logic             input_end_i,
  output jsu_pkg::bundle_t bundle_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        err_q, err_d;

  nibble_t     nib;
  logic [15:0] cp_new;
  logic        err_new;

  assign nib     = hex_nibble(data_byte_i);
  assign cp_new  = nib.ok ? {cp_q[11:0], nib.val} : cp_q;
  assign err_new = err_q | ~nib.ok;

  always_comb begin
    bundle_o = '0;
    bundle_o.status = ST_DATA;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    cp_d   = cp_q;
    err_d  = err_q;
    if (input_end_i) begin
      bundle_o.status = (mode_q == MODE_HEX) ? ST_INCOMPLETE : ST_UNTERMINATED;
      bundle_o.count  = 2'd1;
      mode_d = MODE_NORMAL;
      cnt_d  = '0;
      cp_d   = '0;
      err_d  = 1'b0;
    end else begin
      case (mode_q)
        MODE_ESCAPE: begin
          mode_d = MODE_NORMAL;
          cnt_d  = '0;
          cp_d   = '0;
          err_d  = 1'b0;
          bundle_o.count = 2'd1;
          case (data_byte_i)
            ChQuote, ChBackslash, ChSlash: bundle_o.bytes[0] = data_byte_i;
            ChLowerB: bundle_o.bytes[0] = CtlBackspace;
            ChLowerF: bundle_o.bytes[0] = CtlFormFeed;
            ChLowerN: bundle_o.bytes[0] = CtlNewline;
            ChLowerR: bundle_o.bytes[0] = CtlReturn;
            ChLowerT: bundle_o.bytes[0] = CtlTab;
            ChLowerU: begin
              mode_d = MODE_HEX;
              bundle_o.count = 2'd0;
            end
            default: bundle_o.status = ST_UNSUPPORTED;
          endcase
        end
        MODE_HEX: begin
          cp_d  = cp_new;
          err_d = err_new;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            cp_d   = '0;
            err_d  = 1'b0;
            if (err_new) begin
              bundle_o.status = ST_BAD_HEX;
              bundle_o.count  = 2'd1;
            end else if (cp_new <= OneByteMax) begin
              bundle_o.bytes[0] = cp_new[7:0];
              bundle_o.count    = 2'd1;
            end else if (cp_new <= TwoByteMax) begin
              bundle_o.bytes[0] = LeadTwo | {3'b000, cp_new[10:6]};
              bundle_o.bytes[1] = ContMark | {2'b00, cp_new[5:0]};
              bundle_o.count    = 2'd2;
            end else begin
              bundle_o.bytes[0] = LeadThree | {4'h0, cp_new[15:12]};
              bundle_o.bytes[1] = ContMark | {2'b00, cp_new[11:6]};
              bundle_o.bytes[2] = ContMark | {2'b00, cp_new[5:0]};
              bundle_o.count    = 2'd3;
            end
          end
        end
        default: begin
          if (data_byte_i == ChQuote) begin
            bundle_o.status = ST_CLOSED;
            bundle_o.count  = 2'd1;
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            cp_d   = '0;
            err_d  = 1'b0;
          end else if (data_byte_i == ChBackslash) begin
            mode_d = MODE_ESCAPE;
          end else begin
            mode_d = MODE_NORMAL;
            bundle_o.bytes[0] = data_byte_i;
            bundle_o.count    = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q  <= '0;
      cp_q   <= '0;
      err_q  <= 1'b0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      cp_q   <= cp_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- rtl/core/jsu_outq.sv -----
// Result register: holds one group of up to three results, sends one per cycle
// while out_stall_i is low. Depends on jsu_pkg.
module jsu_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::bundle_t bundle_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import jsu_pkg::*;

  bundle_t    bundle_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       fire;
  logic       done;

  assign out_valid_o = busy_q;
  assign out_byte_o  = bundle_q.bytes[idx_q];
  assign status_o    = (idx_q == 2'd0) ? bundle_q.status : ST_DATA;
  assign last_o      = (idx_q == bundle_q.count - 2'd1);
  assign fire        = busy_q & ~out_stall_i;
  assign done        = fire & last_o;
  // Free now, or the final word of the group leaves this cycle.
  assign ready_o     = ~busy_q | done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (bundle_q.count != 2'd0))
    else $error("result group held with no results");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < bundle_q.count))
    else $error("result index past group size");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_stall_i && !load_i) |=> (busy_q && $stable(idx_q)))
    else $error("result advanced while stalled");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DATA)) |-> last_o)
    else $error("non-data status not alone in its group");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("group loaded over a pending one");

endmodule

// ----- rtl/core/json_string_unescape_utf8_top.sv -----
// Accepted words are registered, then their results load the result register.
// Throughput: one word per cycle unless stalled; a word with several results
// (a \u escape of 2 or 3 UTF-8 bytes) holds the result register until all leave.
// Reset: rst_ni, asynchronous active low, empties the input and result registers
// and returns the decoder to normal byte mode.
// Depends on jsu_pkg, jsu_decode and jsu_outq.
module json_string_unescape_utf8_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       input_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic       in_vld_q;
  logic [7:0] data_q;
  logic       end_q;
  logic       in_accept;
  logic       advance;
  logic       load;
  logic       q_ready;
  bundle_t    bundle;

  // Words with no result move on regardless of the result register.
  assign advance    = in_vld_q & ((bundle.count == 2'd0) | q_ready);
  assign load       = advance & (bundle.count != 2'd0);
  assign in_stall_o = in_vld_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      end_q  <= input_end_i;
    end
  end

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (data_q),
    .input_end_i (end_q),
    .bundle_o    (bundle)
  );

  jsu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (q_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescape_utf8_top: feeds JSON string bodies one
// word at a time, predicts the decoded words and checks each result in order.
// Depends on jsu_pkg and the RTL of the block.
module tb_top;
  import jsu_pkg::*;

  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted   = 40;

  localparam logic [7:0] EscLetters [8] = '{ChQuote, ChBackslash, ChSlash, ChLowerB,
                                            ChLowerF, ChLowerN, ChLowerR, ChLowerT};
  localparam logic [15:0] BoundaryPoints [6] = '{16'h0000, 16'h007F, 16'h0080,
                                                 16'h07FF, 16'h0800, 16'hFFFF};

  typedef struct {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } decoded_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       input_end_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned words_sent     = 0;
  decoded_t    decoded_q [$];

  // Predictor state
  mode_e       esc_mode  = MODE_NORMAL;
  logic [1:0]  digit_cnt = 2'd0;
  logic [15:0] point_acc = 16'h0000;
  logic        bad_digit = 1'b0;

  json_string_unescape_utf8_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .input_end_i (input_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic hex_digit_value(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom_range(255)); while (hex_digit_value(c, v));
    return c;
  endfunction

  task automatic push_decoded(input logic [7:0] d, input status_e st, input logic l);
    decoded_t r;
    r.data   = (st == ST_DATA) ? d : 8'h00;
    r.status = st;
    r.last   = l;
    decoded_q = {decoded_q, r};
  endtask

  task automatic clear_decoder();
    esc_mode  = MODE_NORMAL;
    digit_cnt = 2'd0;
    point_acc = 16'h0000;
    bad_digit = 1'b0;
  endtask

  // Work out the results that one accepted word causes and queue them.
  task automatic unescape_word(input logic [7:0] c, input logic eoi);
    logic [3:0]  nib;
    logic        ok;
    logic        fourth;
    logic [15:0] cp;
    if (eoi) begin
      push_decoded(8'h00, status_e'((esc_mode == MODE_HEX) ? ST_INCOMPLETE : ST_UNTERMINATED),
                   1'b1);
      clear_decoder();
    end else if (esc_mode == MODE_ESCAPE) begin
      clear_decoder();
      case (c)
        ChQuote, ChBackslash, ChSlash: push_decoded(c, ST_DATA, 1'b1);
        ChLowerB: push_decoded(CtlBackspace, ST_DATA, 1'b1);
        ChLowerF: push_decoded(CtlFormFeed, ST_DATA, 1'b1);
        ChLowerN: push_decoded(CtlNewline, ST_DATA, 1'b1);
        ChLowerR: push_decoded(CtlReturn, ST_DATA, 1'b1);
        ChLowerT: push_decoded(CtlTab, ST_DATA, 1'b1);
        ChLowerU: esc_mode = MODE_HEX;
        default:  push_decoded(8'h00, ST_UNSUPPORTED, 1'b1);
      endcase
    end else if (esc_mode == MODE_HEX) begin
      ok     = hex_digit_value(c, nib);
      fourth = (digit_cnt == 2'd3);
      if (ok) point_acc = {point_acc[11:0], nib};
      else bad_digit = 1'b1;
      digit_cnt = digit_cnt + 2'd1;
      if (fourth) begin
        cp = point_acc;
        if (bad_digit) begin
          push_decoded(8'h00, ST_BAD_HEX, 1'b1);
        end else if (cp <= OneByteMax) begin
          push_decoded(cp[7:0], ST_DATA, 1'b1);
        end else if (cp <= TwoByteMax) begin
          push_decoded(LeadTwo | {3'b000, cp[10:6]}, ST_DATA, 1'b0);
          push_decoded(ContMark | {2'b00, cp[5:0]}, ST_DATA, 1'b1);
        end else begin
          push_decoded(LeadThree | {4'h0, cp[15:12]}, ST_DATA, 1'b0);
          push_decoded(ContMark | {2'b00, cp[11:6]}, ST_DATA, 1'b0);
          push_decoded(ContMark | {2'b00, cp[5:0]}, ST_DATA, 1'b1);
        end
        clear_decoder();
      end
    end else begin
      if (c == ChQuote) push_decoded(8'h00, ST_CLOSED, 1'b1);
      else if (c == ChBackslash) esc_mode = MODE_ESCAPE;
      else push_decoded(c, ST_DATA, 1'b1);
    end
  endtask

  // Valid stays high from one word to the next unless a gap is drawn.
  task automatic send_word(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= c;
    input_end_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    unescape_word(c, eoi);
    words_sent++;
  endtask

  task automatic send_unicode(input logic [15:0] cp);
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    for (int i = 3; i >= 0; i--) send_word(hex_char(cp[4*i +: 4]), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_random_sequence();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  c;
    logic [15:0] cp;
    kind = $urandom_range(99);
    if (kind < 35) begin
      do c = 8'($urandom_range(255)); while (c == ChQuote || c == ChBackslash);
      send_word(c, 1'b0);
    end else if (kind < 43) begin
      send_word(ChQuote, 1'b0);
    end else if (kind < 63) begin
      send_word(ChBackslash, 1'b0);
      send_word(EscLetters[$urandom_range(7)], 1'b0);
    end else if (kind < 83) begin
      case ($urandom_range(3))
        0:       cp = 16'($urandom_range(16'h007F));
        1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
        2:       cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: cp = BoundaryPoints[$urandom_range(5)];
      endcase
      send_unicode(cp);
    end else if (kind < 88) begin
      // one bad digit somewhere in the four
      n = $urandom_range(3);
      send_word(ChBackslash, 1'b0);
      send_word(ChLowerU, 1'b0);
      for (int i = 0; i < 4; i++)
        send_word((i == n) ? non_hex_byte() : hex_char(4'($urandom_range(15))), 1'b0);
    end else if (kind < 92) begin
      do c = 8'($urandom_range(255));
      while (c inside {ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN,
                       ChLowerR, ChLowerT, ChLowerU});
      send_word(ChBackslash, 1'b0);
      send_word(c, 1'b0);
    end else if (kind < 97) begin
      // document ends part way through an escape, or in plain text
      n = $urandom_range(5);
      if (n >= 1) send_word(ChBackslash, 1'b0);
      if (n >= 2) send_word(ChLowerU, 1'b0);
      for (int i = 3; i <= int'(n); i++)
        send_word($urandom_range(3) == 0 ? non_hex_byte() : hex_char(4'($urandom_range(15))),
                  1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
    end else begin
      send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  task automatic test_pass_through();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(ChQuote, 1'b0);
    drain();
  endtask

  task automatic test_simple_escapes();
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerT, 1'b0);
    send_word(ChBackslash, 1'b0);
    send_word("q", 1'b0);
    drain();
  endtask

  task automatic test_unicode_escape();
    send_unicode(16'hFFFF);
    drain();
  endtask

  task automatic test_error_endings();
    // bad first digit, reported after the fourth
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    send_word("g", 1'b0);
    send_word("1", 1'b0);
    send_word("2", 1'b0);
    send_word("3", 1'b0);
    send_word(8'hA5, 1'b1);
    send_word(ChBackslash, 1'b0);
    send_word(8'h5A, 1'b1);
    // end while gathering digits after a bad one
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    send_word("z", 1'b0);
    send_word(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_random_stream(input int unsigned n, input int unsigned snd_pct,
                                    input int unsigned rcv_pct);
    int unsigned start;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    start          = words_sent;
    while (words_sent - start < n) send_random_sequence();
    drain();
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report("unexpected word", out_byte_o, 8'h00);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data) report("byte", out_byte_o, want.data);
        if (status_o !== want.status) report("status", 8'(status_o), 8'(want.status));
        if (last_o !== want.last) report("last", 8'(last_o), 8'(want.last));
      end
    end
  end

  // Fail the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_pass_through();
    test_simple_escapes();
    test_unicode_escape();
    test_error_endings();
    test_random_stream(110, 15, 88);
    test_random_stream(110, 88, 15);
    test_random_stream(130, 0, 0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
